/* rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion wrappers used by the checker file.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check on every clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check on every clock edge, reset included
`define ASSERT_CLK_ALL(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/dmd_pkg.sv */
// ---------------------------------------------------------------------------
// dmd_pkg
// Types, constants and the month length table of the date subtractor.
// ---------------------------------------------------------------------------
package dmd_pkg;

   typedef struct packed {
      logic [4:0]  day_in;
      logic [3:0]  month_in;
      logic [13:0] year_in;
      logic [15:0] days_back;
   } req_type;

   typedef struct packed {
      logic [4:0]  day_out;
      logic [3:0]  month_out;
      logic [13:0] year_out;
      logic [1:0]  status;
   } rsp_type;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_BAD_DATE  = 2'd1;
   localparam logic [1:0] ST_UNDERFLOW = 2'd2;

   localparam logic [13:0] YEAR_MAX    = 14'd9999;
   localparam logic [3:0]  MONTH_JAN   = 4'd1;
   localparam logic [3:0]  MONTH_FEB   = 4'd2;
   localparam logic [3:0]  MONTH_DEC   = 4'd12;
   localparam logic [4:0]  DAYS_LONG   = 5'd31;
   localparam logic [8:0]  DAYS_YEAR   = 9'd365;
   localparam logic [6:0]  YEARS_CENT  = 7'd100;
   localparam logic [6:0]  CENT_LAST   = 7'd99;
   // floor(y / 100) == (y * CENT_RECIP) >> CENT_SHIFT for all 14-bit y
   localparam logic [12:0] CENT_RECIP  = 13'd5243;
   localparam int          CENT_SHIFT  = 19;

   typedef logic [3:0] upc_type;

   localparam upc_type UA_WAIT    = 4'd0;
   localparam upc_type UA_SPLIT_Q = 4'd1;
   localparam upc_type UA_SPLIT_R = 4'd2;
   localparam upc_type UA_CHECK   = 4'd3;
   localparam upc_type UA_YEAR    = 4'd4;
   localparam upc_type UA_MONTH   = 4'd5;
   localparam upc_type UA_M_END   = 4'd6;
   localparam upc_type UA_DONE    = 4'd7;
   localparam upc_type UA_BAD     = 4'd8;
   localparam upc_type UA_EMIT    = 4'd9;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_LOAD,
      OP_SPLIT_Q,
      OP_SPLIT_R,
      OP_YEAR_BACK,
      OP_MONTH_BACK,
      OP_FINISH,
      OP_SET_BAD,
      OP_SET_UNDER,
      OP_EMIT
   } op_type;

   typedef enum logic [2:0] {
      CD_NEVER,
      CD_NO_REQ,
      CD_BAD_DATE,
      CD_YEAR_BLOCKED,
      CD_MONTH_STOP,
      CD_N_LT_D,
      CD_OUT_BUSY
   } cond_type;

   // taken: go to jump_addr, skip op; not taken: do op, go to next_addr
   typedef struct packed {
      cond_type cond;
      upc_type  jump_addr;
      op_type   op;
      upc_type  next_addr;
   } ctrl_type;

   typedef struct packed {
      logic no_req;
      logic bad_date;
      logic year_blocked;
      logic month_stop;
      logic n_lt_d;
      logic out_busy;
   } flags_type;

   function automatic logic [4:0] days_in(input logic [3:0] month, input logic leap);
      logic [4:0] len;
      unique case (month)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = DAYS_LONG;
         4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
         MONTH_FEB:                                  len = leap ? 5'd29 : 5'd28;
         default:                                    len = 5'd0;
      endcase
      return len;
   endfunction

endpackage

/* rtl/date_minus_days_top.sv */
// ---------------------------------------------------------------------------
// date_minus_days_top
// Gregorian calendar date minus a count of days.
// ---------------------------------------------------------------------------
// A request carries a date (day, month, year) and a count of days back on
// req_payload; it is taken when req_valid and req_ready are both high. The
// response on rsp_payload gives the earlier date and a status: ok, invalid
// input date, or a result before year one (date fields then zero).
// One request is worked at a time. A microcoded sequencer splits the year
// into century and year of century, checks the date, then steps back one
// whole year per cycle from 31 December and otherwise one month at a time,
// checking for a whole year again after each month. req_ready rises in the
// same cycle as rsp_valid, so the next request can be taken while that
// response is on offer.
// The response sits in an output register: a stalled receiver holds
// rsp_valid and the payload, and the next request is still accepted and
// worked up to the point of handing over its response.
// Synchronous reset clears the sequencer to wait for a request and drops
// any pending response.
// ---------------------------------------------------------------------------
module date_minus_days_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  dmd_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output dmd_pkg::rsp_type rsp_payload
);

   dmd_pkg::flags_type flags;
   dmd_pkg::op_type    op;

   dmd_sequencer u_seq (
      .clock     (clock),
      .reset     (reset),
      .flags     (flags),
      .op        (op),
      .req_ready (req_ready)
   );

   dmd_datapath u_dp (
      .clock       (clock),
      .reset       (reset),
      .op          (op),
      .req_valid   (req_valid),
      .req_payload (req_payload),
      .flags       (flags),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

/* rtl/dmd_ucode_rom.sv */
// ---------------------------------------------------------------------------
// dmd_ucode_rom
// Control store of the date subtractor sequencer.
// ---------------------------------------------------------------------------
module dmd_ucode_rom (
   input  dmd_pkg::upc_type  addr,
   output dmd_pkg::ctrl_type ctrl
);

   always_comb begin
      unique case (addr)
         dmd_pkg::UA_WAIT: ctrl = '{dmd_pkg::CD_NO_REQ, dmd_pkg::UA_WAIT,
                                    dmd_pkg::OP_LOAD, dmd_pkg::UA_SPLIT_Q};
         dmd_pkg::UA_SPLIT_Q: ctrl = '{dmd_pkg::CD_NEVER, dmd_pkg::UA_WAIT,
                                       dmd_pkg::OP_SPLIT_Q, dmd_pkg::UA_SPLIT_R};
         dmd_pkg::UA_SPLIT_R: ctrl = '{dmd_pkg::CD_NEVER, dmd_pkg::UA_WAIT,
                                       dmd_pkg::OP_SPLIT_R, dmd_pkg::UA_CHECK};
         dmd_pkg::UA_CHECK: ctrl = '{dmd_pkg::CD_BAD_DATE, dmd_pkg::UA_BAD,
                                     dmd_pkg::OP_NOP, dmd_pkg::UA_YEAR};
         dmd_pkg::UA_YEAR: ctrl = '{dmd_pkg::CD_YEAR_BLOCKED, dmd_pkg::UA_MONTH,
                                    dmd_pkg::OP_YEAR_BACK, dmd_pkg::UA_YEAR};
         dmd_pkg::UA_MONTH: ctrl = '{dmd_pkg::CD_MONTH_STOP, dmd_pkg::UA_M_END,
                                     dmd_pkg::OP_MONTH_BACK, dmd_pkg::UA_YEAR};
         dmd_pkg::UA_M_END: ctrl = '{dmd_pkg::CD_N_LT_D, dmd_pkg::UA_DONE,
                                     dmd_pkg::OP_SET_UNDER, dmd_pkg::UA_EMIT};
         dmd_pkg::UA_DONE: ctrl = '{dmd_pkg::CD_NEVER, dmd_pkg::UA_WAIT,
                                    dmd_pkg::OP_FINISH, dmd_pkg::UA_EMIT};
         dmd_pkg::UA_BAD: ctrl = '{dmd_pkg::CD_NEVER, dmd_pkg::UA_WAIT,
                                   dmd_pkg::OP_SET_BAD, dmd_pkg::UA_EMIT};
         dmd_pkg::UA_EMIT: ctrl = '{dmd_pkg::CD_OUT_BUSY, dmd_pkg::UA_EMIT,
                                    dmd_pkg::OP_EMIT, dmd_pkg::UA_WAIT};
         default: ctrl = '{dmd_pkg::CD_NEVER, dmd_pkg::UA_WAIT,
                           dmd_pkg::OP_NOP, dmd_pkg::UA_WAIT};
      endcase
   end

endmodule

/* rtl/dmd_sequencer.sv */
// ---------------------------------------------------------------------------
// dmd_sequencer
// Step counter with conditional jumps over the control store.
// ---------------------------------------------------------------------------
module dmd_sequencer (
   input  logic               clock,
   input  logic               reset,
   input  dmd_pkg::flags_type flags,
   output dmd_pkg::op_type    op,
   output logic               req_ready
);

   dmd_pkg::upc_type  upc_ff;
   dmd_pkg::upc_type  upc_in;
   dmd_pkg::ctrl_type ctrl;
   logic              taken;

   dmd_ucode_rom u_rom (
      .addr (upc_ff),
      .ctrl (ctrl)
   );

   always_comb begin
      unique case (ctrl.cond)
         dmd_pkg::CD_NEVER:        taken = 1'b0;
         dmd_pkg::CD_NO_REQ:       taken = flags.no_req;
         dmd_pkg::CD_BAD_DATE:     taken = flags.bad_date;
         dmd_pkg::CD_YEAR_BLOCKED: taken = flags.year_blocked;
         dmd_pkg::CD_MONTH_STOP:   taken = flags.month_stop;
         dmd_pkg::CD_N_LT_D:       taken = flags.n_lt_d;
         dmd_pkg::CD_OUT_BUSY:     taken = flags.out_busy;
         default:                  taken = 1'b0;
      endcase
   end

   assign upc_in    = taken ? ctrl.jump_addr : ctrl.next_addr;
   assign op        = taken ? dmd_pkg::OP_NOP : ctrl.op;
   assign req_ready = (upc_ff == dmd_pkg::UA_WAIT);

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= dmd_pkg::UA_WAIT;
      end else begin
         upc_ff <= upc_in;
      end
   end

endmodule

/* rtl/dmd_datapath.sv */
// ---------------------------------------------------------------------------
// dmd_datapath
// Date registers, year split, month and year borrow, and result register.
// ---------------------------------------------------------------------------
module dmd_datapath (
   input  logic               clock,
   input  logic               reset,
   input  dmd_pkg::op_type    op,
   input  logic               req_valid,
   input  dmd_pkg::req_type   req_payload,
   output dmd_pkg::flags_type flags,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output dmd_pkg::rsp_type   rsp_payload
);

   logic [4:0]       d_ff, d_in;
   logic [3:0]       m_ff, m_in;
   logic [13:0]      y_ff, y_in;
   logic [15:0]      n_ff, n_in;
   logic [7:0]       yq_ff, yq_in;
   logic [6:0]       yr_ff, yr_in;
   logic [1:0]       st_ff, st_in;
   logic             rsp_valid_ff, rsp_valid_in;
   dmd_pkg::rsp_type rsp_ff, rsp_in;

   logic [26:0] q_prod;
   logic [14:0] q_times;
   logic [13:0] r_diff;
   logic        leap;
   logic [4:0]  dim;
   logic [4:0]  dim_prev;
   logic [8:0]  year_len;
   logic        out_busy;

   assign q_prod   = y_ff * dmd_pkg::CENT_RECIP;
   assign q_times  = yq_ff * dmd_pkg::YEARS_CENT;
   assign r_diff   = y_ff - q_times[13:0];
   assign leap     = (yr_ff[1:0] == 2'd0) && ((yr_ff != 7'd0) || (yq_ff[1:0] == 2'd0));
   assign dim      = dmd_pkg::days_in(m_ff, leap);
   assign dim_prev = dmd_pkg::days_in(m_ff - 4'd1, leap);
   assign year_len = dmd_pkg::DAYS_YEAR + {8'd0, leap};
   assign out_busy = rsp_valid_ff && !rsp_ready;

   assign flags.no_req       = !req_valid;
   assign flags.bad_date     = (m_ff == 4'd0) || (m_ff > dmd_pkg::MONTH_DEC) ||
                               (y_ff == 14'd0) || (y_ff > dmd_pkg::YEAR_MAX) ||
                               (d_ff == 5'd0) || (d_ff > dim);
   assign flags.year_blocked = !((m_ff == dmd_pkg::MONTH_DEC) && (d_ff == dmd_pkg::DAYS_LONG) &&
                                 (n_ff >= {7'd0, year_len}) && (y_ff != 14'd1));
   assign flags.n_lt_d       = n_ff < {11'd0, d_ff};
   assign flags.month_stop   = flags.n_lt_d ||
                               ((m_ff == dmd_pkg::MONTH_JAN) && (y_ff == 14'd1));
   assign flags.out_busy     = out_busy;

   always_comb begin
      d_in         = d_ff;
      m_in         = m_ff;
      y_in         = y_ff;
      n_in         = n_ff;
      yq_in        = yq_ff;
      yr_in        = yr_ff;
      st_in        = st_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (op)
         dmd_pkg::OP_NOP: begin
         end
         dmd_pkg::OP_LOAD: begin
            if (req_valid) begin
               d_in = req_payload.day_in;
               m_in = req_payload.month_in;
               y_in = req_payload.year_in;
               n_in = req_payload.days_back;
            end
         end
         dmd_pkg::OP_SPLIT_Q: begin
            yq_in = q_prod[dmd_pkg::CENT_SHIFT +: 8];
         end
         dmd_pkg::OP_SPLIT_R: begin
            yr_in = r_diff[6:0];
         end
         dmd_pkg::OP_YEAR_BACK: begin
            n_in = n_ff - {7'd0, year_len};
            y_in = y_ff - 14'd1;
            if (yr_ff == 7'd0) begin
               yr_in = dmd_pkg::CENT_LAST;
               yq_in = yq_ff - 8'd1;
            end else begin
               yr_in = yr_ff - 7'd1;
            end
         end
         dmd_pkg::OP_MONTH_BACK: begin
            n_in = n_ff - {11'd0, d_ff};
            if (m_ff == dmd_pkg::MONTH_JAN) begin
               m_in = dmd_pkg::MONTH_DEC;
               d_in = dmd_pkg::DAYS_LONG;
               y_in = y_ff - 14'd1;
               if (yr_ff == 7'd0) begin
                  yr_in = dmd_pkg::CENT_LAST;
                  yq_in = yq_ff - 8'd1;
               end else begin
                  yr_in = yr_ff - 7'd1;
               end
            end else begin
               m_in = m_ff - 4'd1;
               d_in = dim_prev;
            end
         end
         dmd_pkg::OP_FINISH: begin
            d_in  = d_ff - n_ff[4:0];
            st_in = dmd_pkg::ST_OK;
         end
         dmd_pkg::OP_SET_BAD: begin
            st_in = dmd_pkg::ST_BAD_DATE;
         end
         dmd_pkg::OP_SET_UNDER: begin
            st_in = dmd_pkg::ST_UNDERFLOW;
         end
         dmd_pkg::OP_EMIT: begin
            if (!out_busy) begin
               rsp_valid_in = 1'b1;
               if (st_ff == dmd_pkg::ST_OK) begin
                  rsp_in = '{d_ff, m_ff, y_ff, dmd_pkg::ST_OK};
               end else begin
                  rsp_in = '{5'd0, 4'd0, 14'd0, st_ff};
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         st_ff        <= dmd_pkg::ST_OK;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         st_ff        <= st_in;
      end
   end

   always_ff @(posedge clock) begin
      d_ff   <= d_in;
      m_ff   <= m_in;
      y_ff   <= y_in;
      n_ff   <= n_in;
      yq_ff  <= yq_in;
      yr_ff  <= yr_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

/* rtl/dmd_checker.sv */
// ---------------------------------------------------------------------------
// dmd_checker
// Port-level checks of the date subtractor, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module dmd_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input dmd_pkg::rsp_type rsp_payload
);

   `ASSERT_CLK(a_rsp_hold, clock, reset, (rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload)), "response dropped or changed while stalled")
   `ASSERT_CLK_ALL(a_reset_clear, clock, (reset |=> !rsp_valid), "response valid after reset")
   `ASSERT_CLK(a_busy_after_req, clock, reset, (req_valid && req_ready |=> !req_ready), "request taken while busy")
   `ASSERT_CLK(a_ok_range, clock, reset, (rsp_valid && rsp_payload.status == dmd_pkg::ST_OK |-> rsp_payload.day_out != 5'd0 && rsp_payload.month_out != 4'd0 && rsp_payload.month_out <= dmd_pkg::MONTH_DEC && rsp_payload.year_out != 14'd0 && rsp_payload.year_out <= dmd_pkg::YEAR_MAX), "ok response out of range")
   `ASSERT_CLK(a_err_zero, clock, reset, (rsp_valid && rsp_payload.status != dmd_pkg::ST_OK |-> (rsp_payload.status == dmd_pkg::ST_BAD_DATE || rsp_payload.status == dmd_pkg::ST_UNDERFLOW) && rsp_payload.day_out == 5'd0 && rsp_payload.month_out == 4'd0 && rsp_payload.year_out == 14'd0), "error response not cleared")

endmodule

bind date_minus_days_top dmd_checker u_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);
